// ===== rtl/core/pgrm_pkg.sv =====
package pgrm_pkg;

	localparam int LEN_W = 16;
	localparam int PS_W = 20;
	localparam int PROD_W = LEN_W + PS_W;

	localparam logic [PS_W-1:0] PS_RESET = 20'd800;

	// Division by 1000 is a right shift by 3 followed by a division by 125.
	// The division by 125 multiplies by floor(2^32 / 125), which leaves the
	// quotient at most one below the true value; a remainder check fixes it.
	localparam int DIV_PRE_SHIFT = 3;
	localparam int DIV_Y_W = PROD_W - DIV_PRE_SHIFT;
	localparam int DIV_MULT_W = 26;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = 26'd34359738;
	localparam int DIV_SHIFT = 32;
	localparam int DIV_PROD_W = DIV_Y_W + DIV_MULT_W;
	localparam int QUOT_W = 27;
	localparam int REM_W = 8;
	localparam logic [REM_W-1:0] DIV_BY = 8'd125;

	typedef struct packed {
		logic has_prev;
		logic span_en;
	} pgrm_info_t;

endpackage

// ===== rtl/core/pgrm_ring.sv =====
module pgrm_ring import pgrm_pkg::*; #(
	parameter int WINDOW = 30,
	parameter int TIME_BITS = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [TIME_BITS-1:0] arrival,
	output logic [TIME_BITS-1:0] first_arrival,
	output pgrm_info_t           info
);

	localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);

	logic [TIME_BITS-1:0] mem [WINDOW];
	logic [TIME_BITS-1:0] rd_q;
	logic [PTR_W-1:0]     ptr_q;
	logic [PTR_W-1:0]     rd_addr;
	logic [PTR_W-1:0]     ptr_next;
	logic [CNT_W-1:0]     cnt_q;
	pgrm_info_t           info_q;

	assign ptr_next = (ptr_q == PTR_W'(WINDOW - 1)) ? '0 : ptr_q + 1'b1;
	assign rd_addr = ptr_next;

	// The entry after the write slot is the arrival from WINDOW-1 packets back.
	always_ff @(posedge clk) begin
		if (wr) begin
			mem[ptr_q] <= arrival;
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			cnt_q <= '0;
			info_q <= '0;
		end else if (wr) begin
			ptr_q <= ptr_next;
			if (cnt_q != CNT_W'(WINDOW)) begin
				cnt_q <= cnt_q + 1'b1;
			end
			info_q.has_prev <= (cnt_q != '0);
			info_q.span_en <= (cnt_q >= CNT_W'(WINDOW - 1));
		end
	end

	assign first_arrival = rd_q;
	assign info = info_q;

`ifndef SYNTHESIS
	a_span_needs_prev: assert property (@(posedge clk) disable iff (!arst_n)
		info_q.span_en |-> info_q.has_prev)
		else $error("span enabled without a previous packet");

	a_ptr_tracks_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q < CNT_W'(WINDOW)) |-> (CNT_W'(ptr_q) == cnt_q))
		else $error("ring pointer out of step with fill count");

	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PTR_W'(WINDOW - 1))
		else $error("ring pointer beyond the last entry");
`endif

endmodule

// ===== rtl/core/pgrm_stats.sv =====
module pgrm_stats import pgrm_pkg::*; #(
	parameter int TIME_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        upd,
	input  logic [LEN_W-1:0]            len,
	input  pgrm_info_t                  info,
	input  logic signed [TIME_BITS:0]   gap,
	input  logic [TIME_BITS-1:0]        span,
	output logic [LEN_W-1:0]            min_length,
	output logic [LEN_W-1:0]            max_length,
	output logic                        gap_valid,
	output logic signed [TIME_BITS:0]   min_gap_ns,
	output logic signed [TIME_BITS:0]   max_gap_ns,
	output logic                        span_valid,
	output logic [TIME_BITS-1:0]        min_span_ns,
	output logic [TIME_BITS-1:0]        max_span_ns
);

	logic [LEN_W-1:0]          min_len_q;
	logic [LEN_W-1:0]          max_len_q;
	logic                      gap_valid_q;
	logic signed [TIME_BITS:0] min_gap_q;
	logic signed [TIME_BITS:0] max_gap_q;
	logic                      span_valid_q;
	logic [TIME_BITS-1:0]      min_span_q;
	logic [TIME_BITS-1:0]      max_span_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= '1;
			max_len_q <= '0;
			gap_valid_q <= 1'b0;
			min_gap_q <= '0;
			max_gap_q <= '0;
			span_valid_q <= 1'b0;
			min_span_q <= '0;
			max_span_q <= '0;
		end else if (upd) begin
			if (len < min_len_q) begin
				min_len_q <= len;
			end
			if (len > max_len_q) begin
				max_len_q <= len;
			end
			if (info.has_prev) begin
				gap_valid_q <= 1'b1;
				if (!gap_valid_q || (gap < min_gap_q)) begin
					min_gap_q <= gap;
				end
				if (!gap_valid_q || (gap > max_gap_q)) begin
					max_gap_q <= gap;
				end
			end
			if (info.span_en) begin
				span_valid_q <= 1'b1;
				if (!span_valid_q || (span < min_span_q)) begin
					min_span_q <= span;
				end
				if (!span_valid_q || (span > max_span_q)) begin
					max_span_q <= span;
				end
			end
		end
	end

	assign min_length = min_len_q;
	assign max_length = max_len_q;
	assign gap_valid = gap_valid_q;
	assign min_gap_ns = min_gap_q;
	assign max_gap_ns = max_gap_q;
	assign span_valid = span_valid_q;
	assign min_span_ns = min_span_q;
	assign max_span_ns = max_span_q;

`ifndef SYNTHESIS
	a_len_order: assert property (@(posedge clk) disable iff (!arst_n)
		upd |=> (min_len_q <= max_len_q))
		else $error("length minimum above maximum");

	a_gap_order: assert property (@(posedge clk) disable iff (!arst_n)
		gap_valid_q |-> (min_gap_q <= max_gap_q))
		else $error("gap minimum above maximum");

	a_span_after_gap: assert property (@(posedge clk) disable iff (!arst_n)
		span_valid_q |-> (gap_valid_q && (min_span_q <= max_span_q)))
		else $error("span statistics inconsistent");
`endif

endmodule

// ===== rtl/core/packet_gap_and_rate_monitor.sv =====
// Packet gap and rate monitor.
// The input channel carries one packet per transaction: arrival_ns and
// length_bytes. The output channel carries one transaction of running
// statistics per packet, in order: length extremes, gap extremes once two
// packets have been seen, and window span extremes once WINDOW packets
// have been seen. The cfg_we and cfg_wdata port sets the wire time of one
// byte in picoseconds; the user must write it only while the block is idle,
// which the block itself does not enforce. It takes one packet per cycle
// while in_stall is low. Each result passes through a pipeline of multiply,
// reciprocal divide, correction and gap stages ahead of the statistics
// registers. The window ring has one write port and one registered read
// port, each used once per packet, so it sustains one packet per cycle.
// When the receiver stalls, the held result stays on the outputs and the
// pipeline keeps filling its empty stages; in_stall rises only when every
// stage holds a packet.
// Reset clears the pipeline, the previous packet, the ring pointer and fill
// count, and the statistics, and sets the byte time to 800 ps. The ring
// memory is not cleared, since an entry is used only after it is written.
module packet_gap_and_rate_monitor import pgrm_pkg::*; #(
	parameter int WINDOW = 30,
	parameter int TIME_BITS = 48
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [PS_W-1:0]             cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [TIME_BITS-1:0]        arrival_ns,
	input  logic [LEN_W-1:0]            length_bytes,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [LEN_W-1:0]            min_length,
	output logic [LEN_W-1:0]            max_length,
	output logic                        gap_valid,
	output logic signed [TIME_BITS:0]   min_gap_ns,
	output logic signed [TIME_BITS:0]   max_gap_ns,
	output logic                        span_valid,
	output logic [TIME_BITS-1:0]        min_span_ns,
	output logic [TIME_BITS-1:0]        max_span_ns
);

	logic [PS_W-1:0]      ps_q;
	logic [TIME_BITS-1:0] last_arr_q;
	logic [LEN_W-1:0]     last_len_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4, out_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;
	logic accept;

	logic [TIME_BITS-1:0] arr_s1;
	logic [TIME_BITS:0]   dt_s1, dt_s2, dt_s3;
	logic [LEN_W-1:0]     len_s1, len_s2, len_s3, len_s4;
	logic [PROD_W-1:0]    prod_s1;
	logic [TIME_BITS-1:0] first_arrival;
	pgrm_info_t           info_s1, info_s2, info_s3, info_s4;

	logic [DIV_Y_W-1:0]    y_s1, y_s2;
	logic [DIV_PROD_W-1:0] qm;
	logic [QUOT_W-1:0]     qe_s2;
	logic [TIME_BITS-1:0]  span_d, span_s2, span_s3, span_s4;

	logic [DIV_Y_W-1:0] rem_full;
	logic [REM_W-1:0]   rem;
	logic [QUOT_W-1:0]  q_s3;

	logic [TIME_BITS+1:0]      diff;
	logic                      sat;
	logic signed [TIME_BITS:0] gap_d, gap_s4;

	// Each stage moves on when the stage after it is empty or moving.
	assign rdy_out = !out_valid_q || !out_stall;
	assign rdy_s4 = !vld_s4 || rdy_out;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;
	assign in_stall = !rdy_s1;
	assign accept = in_valid && rdy_s1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= PS_RESET;
			last_arr_q <= '0;
			last_len_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ps_q <= cfg_wdata;
			end
			if (accept) begin
				last_arr_q <= arrival_ns;
				last_len_q <= length_bytes;
			end
			if (rdy_s1) begin
				vld_s1 <= in_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
			if (rdy_out) begin
				out_valid_q <= vld_s4;
			end
		end
	end

	pgrm_ring #(
		.WINDOW(WINDOW),
		.TIME_BITS(TIME_BITS)
	) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.wr(accept),
		.arrival(arrival_ns),
		.first_arrival(first_arrival),
		.info(info_s1)
	);

	// Stage 1: wire time of the previous packet in picoseconds, at the byte
	// time in force now, and the arrival delta from the previous packet.
	always_ff @(posedge clk) begin
		if (accept) begin
			arr_s1 <= arrival_ns;
			len_s1 <= length_bytes;
			dt_s1 <= {1'b0, arrival_ns} - {1'b0, last_arr_q};
			prod_s1 <= PROD_W'(last_len_q) * PROD_W'(ps_q);
		end
	end

	// Stage 2: estimated quotient and window span.
	assign y_s1 = prod_s1[PROD_W-1:DIV_PRE_SHIFT];
	assign qm = DIV_PROD_W'(y_s1) * DIV_PROD_W'(DIV_MULT);
	assign span_d = (arr_s1 >= first_arrival) ? arr_s1 - first_arrival : '0;

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			dt_s2 <= dt_s1;
			len_s2 <= len_s1;
			info_s2 <= info_s1;
			y_s2 <= y_s1;
			qe_s2 <= qm[DIV_SHIFT+QUOT_W-1:DIV_SHIFT];
			span_s2 <= span_d;
		end
	end

	// Stage 3: the remainder is below twice the divisor, so one step corrects.
	assign rem_full = y_s2 - DIV_Y_W'(qe_s2) * DIV_Y_W'(DIV_BY);
	assign rem = rem_full[REM_W-1:0];

	always_ff @(posedge clk) begin
		if (vld_s2 && rdy_s3) begin
			dt_s3 <= dt_s2;
			len_s3 <= len_s2;
			info_s3 <= info_s2;
			q_s3 <= qe_s2 + QUOT_W'(rem >= DIV_BY);
			span_s3 <= span_s2;
		end
	end

	// Stage 4: gap against the end of the previous packet, saturated below.
	assign diff = {dt_s3[TIME_BITS], dt_s3} - (TIME_BITS + 2)'(q_s3);
	assign sat = diff[TIME_BITS+1] && !diff[TIME_BITS];
	assign gap_d = sat ? {1'b1, {TIME_BITS{1'b0}}} : diff[TIME_BITS:0];

	always_ff @(posedge clk) begin
		if (vld_s3 && rdy_s4) begin
			len_s4 <= len_s3;
			info_s4 <= info_s3;
			gap_s4 <= gap_d;
			span_s4 <= span_s3;
		end
	end

	pgrm_stats #(
		.TIME_BITS(TIME_BITS)
	) u_stats (
		.clk(clk),
		.arst_n(arst_n),
		.upd(vld_s4 && rdy_out),
		.len(len_s4),
		.info(info_s4),
		.gap(gap_s4),
		.span(span_s4),
		.min_length(min_length),
		.max_length(max_length),
		.gap_valid(gap_valid),
		.min_gap_ns(min_gap_ns),
		.max_gap_ns(max_gap_ns),
		.span_valid(span_valid),
		.min_span_ns(min_span_ns),
		.max_span_ns(max_span_ns)
	);

endmodule
